// File: sv/nclmm_pkg.sv
// Package: element type codes and helpers shared by the min/max tracker.
package nclmm_pkg;

  typedef enum logic [3:0] {
    TYPE_S8  = 4'd0,
    TYPE_S16 = 4'd1,
    TYPE_S32 = 4'd2,
    TYPE_S64 = 4'd3,
    TYPE_U8  = 4'd4,
    TYPE_U16 = 4'd5,
    TYPE_U32 = 4'd6,
    TYPE_U64 = 4'd7,
    TYPE_F32 = 4'd8,
    TYPE_F64 = 4'd9
  } elem_type_e;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned TypeWidth  = 4;

  // Map unused codes onto unsigned 64-bit
  function automatic elem_type_e norm_type(logic [TypeWidth-1:0] code);
    elem_type_e t;
    t = TYPE_U64;
    case (code)
      4'd0: t = TYPE_S8;
      4'd1: t = TYPE_S16;
      4'd2: t = TYPE_S32;
      4'd3: t = TYPE_S64;
      4'd4: t = TYPE_U8;
      4'd5: t = TYPE_U16;
      4'd6: t = TYPE_U32;
      4'd7: t = TYPE_U64;
      4'd8: t = TYPE_F32;
      4'd9: t = TYPE_F64;
      default: t = TYPE_U64;
    endcase
    return t;
  endfunction

  // Keep only the low type-width bits
  function automatic logic [ValueWidth-1:0] type_mask(elem_type_e t);
    logic [ValueWidth-1:0] m;
    m = '1;
    case (t)
      TYPE_S8, TYPE_U8:             m = 64'h0000_0000_0000_00FF;
      TYPE_S16, TYPE_U16:           m = 64'h0000_0000_0000_FFFF;
      TYPE_S32, TYPE_U32, TYPE_F32: m = 64'h0000_0000_FFFF_FFFF;
      default:                      m = '1;
    endcase
    return m;
  endfunction

  // Detect a NaN; integer types never carry one
  function automatic logic is_nan(logic [ValueWidth-1:0] v, elem_type_e t);
    logic r;
    r = 1'b0;
    case (t)
      TYPE_F32: r = (&v[30:23]) && (|v[22:0]);
      TYPE_F64: r = (&v[62:52]) && (|v[51:0]);
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/nclmm_in_if.sv
// Interface: column element / finish request channel.
interface nclmm_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] value_bits;
  logic        is_null;

  modport source (output valid, op, value_bits, is_null, input ready);
  modport sink   (input valid, op, value_bits, is_null, output ready);
endinterface

// File: sv/nclmm_out_if.sv
// Interface: min/max result channel.
interface nclmm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] min_bits;
  logic [63:0] max_bits;
  logic        result_is_null;

  modport source (output valid, min_bits, max_bits, result_is_null, input ready);
  modport sink   (input valid, min_bits, max_bits, result_is_null, output ready);
endinterface

// File: sv/nullable_column_min_max.sv
// Top level: running min/max over a nullable column.
//
//   port    | dir | payload                                 | handshake
//   in_i    | in  | op, value_bits, is_null                 | valid/ready
//   out_o   | out | min_bits, max_bits, result_is_null      | valid/ready
//   cfg     | in  | cfg_wdata_i (element type)              | cfg_we_i
//
// One request per cycle is taken unless a finish is waiting (see below); each is
// folded into min/max by one compare pair while it sits in the input register.
// A finish request passes through the input register, then the result register, to out_o.
// Reset clears the type register, the tracking state and both valid flags.
// A finish request waits in the input register while the result register
// is still full and stalled; element requests never wait there.
module nullable_column_min_max
  import nclmm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  nclmm_in_if.sink             in_i,
  nclmm_out_if.source          out_o,
  input  logic                 cfg_we_i,
  input  logic [TypeWidth-1:0] cfg_wdata_i
);

  logic [TypeWidth-1:0]  type_q;
  logic                  stg_v_q;
  logic                  stg_op_q, stg_null_q;
  logic [ValueWidth-1:0] stg_val_q;
  logic                  seen_nn_q, seen_num_q;
  logic [ValueWidth-1:0] min_q, max_q;
  logic                  out_v_q, out_null_q;
  logic [ValueWidth-1:0] out_min_q, out_max_q;

  elem_type_e            etype;
  logic [ValueWidth-1:0] mask, x, lo, hi;
  logic                  x_nan, x_lt_lo, hi_lt_x;
  logic                  stg_go, out_free;
  logic                  seen_nn_d, seen_num_d;
  logic [ValueWidth-1:0] min_d, max_d;

  assign etype = norm_type(type_q);
  assign mask  = type_mask(etype);
  assign x     = stg_val_q & mask;
  assign lo    = min_q & mask;
  assign hi    = max_q & mask;
  assign x_nan = is_nan(x, etype);

  nclmm_cmp u_cmp_lo (.a_i(x),  .b_i(lo), .type_i(etype), .lt_o(x_lt_lo));
  nclmm_cmp u_cmp_hi (.a_i(hi), .b_i(x),  .type_i(etype), .lt_o(hi_lt_x));

  // Handshake: finish needs a free result register
  assign out_free   = !out_v_q || out_o.ready;
  assign stg_go     = stg_v_q && (!stg_op_q || out_free);
  assign in_i.ready = !stg_v_q || stg_go;

  // Fold one element into the tracking state, or clear it on finish
  always_comb begin
    seen_nn_d  = seen_nn_q;
    seen_num_d = seen_num_q;
    min_d      = min_q;
    max_d      = max_q;
    if (stg_go) begin
      if (stg_op_q) begin
        seen_nn_d  = 1'b0;
        seen_num_d = 1'b0;
        min_d      = '0;
        max_d      = '0;
      end else if (!stg_null_q) begin
        if (!seen_nn_q) begin
          min_d      = x;
          max_d      = x;
          seen_nn_d  = 1'b1;
          seen_num_d = !x_nan;
        end else if (!x_nan) begin
          if (!seen_num_q) begin
            min_d      = x;
            max_d      = x;
            seen_num_d = 1'b1;
          end else if (x_lt_lo) begin
            min_d = x;
          end else if (hi_lt_x) begin
            max_d = x;
          end
        end
      end
    end
  end

  // Hold the type register and the tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q     <= '0;
      seen_nn_q  <= 1'b0;
      seen_num_q <= 1'b0;
      min_q      <= '0;
      max_q      <= '0;
    end else begin
      if (cfg_we_i) type_q <= cfg_wdata_i;
      seen_nn_q  <= seen_nn_d;
      seen_num_q <= seen_num_d;
      min_q      <= min_d;
      max_q      <= max_d;
    end
  end

  // Capture a request into the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else if (in_i.ready) begin
      stg_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      stg_op_q   <= in_i.op;
      stg_val_q  <= in_i.value_bits;
      stg_null_q <= in_i.is_null;
    end
  end

  // Load the result register on finish, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (stg_go && stg_op_q) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_go && stg_op_q) begin
      out_null_q <= !seen_nn_q;
      out_min_q  <= seen_nn_q ? lo : '0;
      out_max_q  <= seen_nn_q ? hi : '0;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.min_bits       = out_min_q;
  assign out_o.max_bits       = out_max_q;
  assign out_o.result_is_null = out_null_q;

  // A finish clears the tracking state
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_go && stg_op_q |=> !seen_nn_q && !seen_num_q)
    else $error("state not cleared after finish");

  // A number seen implies a non-null element seen
  a_seen_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_num_q |-> seen_nn_q)
    else $error("seen_number without seen_non_null");

  // A null result carries zero bounds
  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_null_q |-> (out_min_q == '0) && (out_max_q == '0))
    else $error("null result with non-zero bounds");

  // A finish never overwrites an untaken result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_go && stg_op_q |-> !out_v_q || out_o.ready)
    else $error("result overwritten");

endmodule

// File: sv/nclmm_cmp.sv
// Less-than compare of two masked values under the element type.
module nclmm_cmp
  import nclmm_pkg::*;
(
  input  logic [ValueWidth-1:0] a_i,
  input  logic [ValueWidth-1:0] b_i,
  input  elem_type_e            type_i,
  output logic                  lt_o
);

  logic        sa32, sb32, sa64, sb64;
  logic [30:0] ma32, mb32;
  logic [62:0] ma64, mb64;
  logic        f32_lt, f64_lt;
  logic [ValueWidth-1:0] sign_flip;

  assign sa32 = a_i[31];
  assign sb32 = b_i[31];
  assign ma32 = a_i[30:0];
  assign mb32 = b_i[30:0];
  assign sa64 = a_i[63];
  assign sb64 = b_i[63];
  assign ma64 = a_i[62:0];
  assign mb64 = b_i[62:0];

  // IEEE order: NaN never less, signed zeros equal
  always_comb begin
    f32_lt = 1'b0;
    if (!is_nan(a_i, TYPE_F32) && !is_nan(b_i, TYPE_F32) &&
        !((ma32 == '0) && (mb32 == '0))) begin
      if (sa32 && !sb32)       f32_lt = 1'b1;
      else if (!sa32 && !sb32) f32_lt = ma32 < mb32;
      else if (sa32 && sb32)   f32_lt = ma32 > mb32;
      else                     f32_lt = 1'b0;
    end
  end

  always_comb begin
    f64_lt = 1'b0;
    if (!is_nan(a_i, TYPE_F64) && !is_nan(b_i, TYPE_F64) &&
        !((ma64 == '0) && (mb64 == '0))) begin
      if (sa64 && !sb64)       f64_lt = 1'b1;
      else if (!sa64 && !sb64) f64_lt = ma64 < mb64;
      else if (sa64 && sb64)   f64_lt = ma64 > mb64;
      else                     f64_lt = 1'b0;
    end
  end

  // Flip the sign bit so signed order becomes unsigned order
  always_comb begin
    sign_flip = '0;
    case (type_i)
      TYPE_S8:  sign_flip[7]  = 1'b1;
      TYPE_S16: sign_flip[15] = 1'b1;
      TYPE_S32: sign_flip[31] = 1'b1;
      TYPE_S64: sign_flip[63] = 1'b1;
      default:  sign_flip = '0;
    endcase
  end

  always_comb begin
    case (type_i)
      TYPE_F32: lt_o = f32_lt;
      TYPE_F64: lt_o = f64_lt;
      default:  lt_o = (a_i ^ sign_flip) < (b_i ^ sign_flip);
    endcase
  end

endmodule
